>>> sv/svl_pkg.sv
// ----------------------------------------------------------------------------
// svl_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted value list.
// ----------------------------------------------------------------------------
package svl_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 6;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CLEAR,
        IDX_LOAD_COUNT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // Controller to datapath.
    typedef struct packed {
        logic              load;
        idx_op_t           idx_op;
        logic              rd_en;
        rd_sel_t           rd_sel;
        logic              wr_en;
        logic              wr_value;     // 1: write the command value, 0: read data
        cnt_op_t           cnt_op;
        logic              emit;
        logic [STAT_W-1:0] emit_status;
        logic              emit_entry;   // 1: result carries the read data
        logic              emit_last;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             idx_zero;
        logic             idx_end;
        logic             idx_next_end;
        logic             rd_ge;
        logic             rd_eq;
    } dp_stat_t;

endpackage

>>> sv/svl_ram.sv
// ----------------------------------------------------------------------------
// svl_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module svl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/svl_dp.sv
// ----------------------------------------------------------------------------
// svl_dp
// Datapath: entry RAM, index and count registers, comparators and the
// result registers.
// ----------------------------------------------------------------------------
module svl_dp #(
    parameter int DEPTH = svl_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  svl_pkg::dp_cmd_t                  ctl,
    output svl_pkg::dp_stat_t                 stat,
    input  logic [svl_pkg::CMD_W-1:0]         cmd,
    input  logic signed [svl_pkg::DATA_W-1:0] value,
    output logic                              result_valid,
    output logic signed [svl_pkg::DATA_W-1:0] entry_value,
    output logic [svl_pkg::STAT_W-1:0]        status,
    output logic [svl_pkg::CNT_W-1:0]         entry_count,
    output logic                              last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [svl_pkg::CMD_W-1:0]         cmd_reg;
    logic signed [svl_pkg::DATA_W-1:0] value_reg;
    logic [CW-1:0]                     idx_reg;
    logic [CW-1:0]                     idx_next;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [CW-1:0]                     rd_idx;
    logic signed [svl_pkg::DATA_W-1:0] rd_data;
    logic signed [svl_pkg::DATA_W-1:0] wr_data;
    logic [CW:0]                       idx_plus1;

    logic                              valid_reg;
    logic signed [svl_pkg::DATA_W-1:0] entry_value_reg;
    logic [svl_pkg::STAT_W-1:0]        status_reg;
    logic [svl_pkg::CNT_W-1:0]         entry_count_reg;
    logic                              last_reg;

    always_comb
    begin
        unique case (ctl.rd_sel)
            svl_pkg::RD_PREV: rd_idx = idx_reg - CW'(1);
            svl_pkg::RD_NEXT: rd_idx = idx_reg + CW'(1);
            default:          rd_idx = idx_reg;
        endcase
    end

    assign wr_data = ctl.wr_value ? value_reg : rd_data;

    svl_ram #(
        .WIDTH (svl_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        unique case (ctl.idx_op)
            svl_pkg::IDX_CLEAR:      idx_next = '0;
            svl_pkg::IDX_LOAD_COUNT: idx_next = count_reg;
            svl_pkg::IDX_INC:        idx_next = idx_reg + CW'(1);
            svl_pkg::IDX_DEC:        idx_next = idx_reg - CW'(1);
            default:                 idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctl.cnt_op)
            svl_pkg::CNT_INC: count_next = count_reg + CW'(1);
            svl_pkg::CNT_DEC: count_next = count_reg - CW'(1);
            default:          count_next = count_reg;
        endcase
    end

    assign idx_plus1 = {1'b0, idx_reg} + (CW+1)'(1);

    assign stat.cmd          = cmd_reg;
    assign stat.full         = (count_reg == CW'(DEPTH));
    assign stat.empty        = (count_reg == '0);
    assign stat.idx_zero     = (idx_reg == '0);
    assign stat.idx_end      = (idx_reg == count_reg);
    assign stat.idx_next_end = (idx_plus1 >= {1'b0, count_reg});
    assign stat.rd_ge        = (rd_data >= value_reg);
    assign stat.rd_eq        = (rd_data == value_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= ctl.emit;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
        end
        if (ctl.emit)
        begin
            entry_value_reg <= ctl.emit_entry ? rd_data : '0;
            status_reg      <= ctl.emit_status;
            entry_count_reg <= svl_pkg::CNT_W'(count_next);
            last_reg        <= ctl.emit_last;
        end
    end

    assign result_valid = valid_reg;
    assign entry_value  = entry_value_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;
    assign last         = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (idx_reg <= count_reg && idx_reg < CW'(DEPTH)))
        else $error("write beyond the stored entries");

endmodule

>>> sv/svl_ctrl.sv
// ----------------------------------------------------------------------------
// svl_ctrl
// Controller: sequences the scan, shift and list walks over the entry RAM.
// ----------------------------------------------------------------------------
module svl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  svl_pkg::dp_stat_t stat,
    output svl_pkg::dp_cmd_t  ctl
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_REM_CHK,
        ST_REM_CMP,
        ST_SH_CHK,
        ST_SH_WR,
        ST_LST_RD,
        ST_LST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.cmd)
                    svl_pkg::CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_status = svl_pkg::ST_FULL;
                            ctl.emit_last   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            ctl.idx_op = svl_pkg::IDX_LOAD_COUNT;
                            state_next = ST_INS_CHK;
                        end
                    end
                    svl_pkg::CMD_REMOVE:
                    begin
                        ctl.idx_op = svl_pkg::IDX_CLEAR;
                        state_next = ST_REM_CHK;
                    end
                    svl_pkg::CMD_LIST:
                    begin
                        if (stat.empty)
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_status = svl_pkg::ST_EMPTY;
                            ctl.emit_last   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            ctl.idx_op = svl_pkg::IDX_CLEAR;
                            state_next = ST_LST_RD;
                        end
                    end
                    default:
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = svl_pkg::ST_OK;
                        ctl.emit_last   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                endcase
            end
            // Insert walks down from the top, moving every entry that is not
            // below the new value up by one place.
            ST_INS_CHK:
            begin
                if (stat.idx_zero)
                begin
                    ctl.wr_en       = 1'b1;
                    ctl.wr_value    = 1'b1;
                    ctl.cnt_op      = svl_pkg::CNT_INC;
                    ctl.emit        = 1'b1;
                    ctl.emit_status = svl_pkg::ST_OK;
                    ctl.emit_last   = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = svl_pkg::RD_PREV;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (stat.rd_ge)
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.idx_op = svl_pkg::IDX_DEC;
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    ctl.wr_en       = 1'b1;
                    ctl.wr_value    = 1'b1;
                    ctl.cnt_op      = svl_pkg::CNT_INC;
                    ctl.emit        = 1'b1;
                    ctl.emit_status = svl_pkg::ST_OK;
                    ctl.emit_last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_REM_CHK:
            begin
                if (stat.idx_end)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = svl_pkg::ST_NOTFOUND;
                    ctl.emit_last   = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = svl_pkg::RD_CUR;
                    state_next = ST_REM_CMP;
                end
            end
            ST_REM_CMP:
            begin
                if (stat.rd_eq)
                begin
                    state_next = ST_SH_CHK;
                end
                else
                begin
                    ctl.idx_op = svl_pkg::IDX_INC;
                    state_next = ST_REM_CHK;
                end
            end
            // Close the gap left by the removed entry, one entry per pass.
            ST_SH_CHK:
            begin
                if (stat.idx_next_end)
                begin
                    ctl.cnt_op      = svl_pkg::CNT_DEC;
                    ctl.emit        = 1'b1;
                    ctl.emit_status = svl_pkg::ST_OK;
                    ctl.emit_last   = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = svl_pkg::RD_NEXT;
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.idx_op = svl_pkg::IDX_INC;
                state_next = ST_SH_CHK;
            end
            ST_LST_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = svl_pkg::RD_CUR;
                state_next = ST_LST_OUT;
            end
            ST_LST_OUT:
            begin
                ctl.emit        = 1'b1;
                ctl.emit_status = svl_pkg::ST_OK;
                ctl.emit_entry  = 1'b1;
                ctl.emit_last   = stat.idx_next_end;
                if (stat.idx_next_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.idx_op = svl_pkg::IDX_INC;
                    state_next = ST_LST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && ctl.emit_last) |=> (state_reg == ST_IDLE && !busy))
        else $error("final result beat without a return to idle");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!ctl.emit && !ctl.wr_en))
        else $error("result or write issued while idle");

endmodule

>>> sv/sorted_value_list_top.sv
// ----------------------------------------------------------------------------
// sorted_value_list_top
// Bounded table of signed values in hundredths, kept in ascending order,
// with insert, remove and list commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; the block then
// handles one command at a time. Every result beat is shown for exactly one
// cycle with result_valid high and must be captured then, since the receiver
// cannot stall; last marks the final beat of a command. The entries live in
// a single-port-read RAM, so each step of a walk is a read followed by a
// compare, a write or a result beat. An insert into a full table, a list of
// an empty table and the spare command code are answered without a walk.
// Reading the RAM is the limiting resource.
// ----------------------------------------------------------------------------
module sorted_value_list_top #(
    parameter int DEPTH = svl_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [svl_pkg::CMD_W-1:0]         cmd,
    input  logic signed [svl_pkg::DATA_W-1:0] value,
    output logic                              result_valid,
    output logic signed [svl_pkg::DATA_W-1:0] entry_value,
    output logic [svl_pkg::STAT_W-1:0]        status,
    output logic [svl_pkg::CNT_W-1:0]         entry_count,
    output logic                              last
);

    svl_pkg::dp_cmd_t  ctl;
    svl_pkg::dp_stat_t stat;

    svl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    svl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cmd          (cmd),
        .value        (value),
        .result_valid (result_valid),
        .entry_value  (entry_value),
        .status       (status),
        .entry_count  (entry_count),
        .last         (last)
    );

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted value list. A local table model
// predicts the result beats of every accepted command, and the beats that
// come out of the block are compared against them field by field. Directed
// tests cover the empty table and the value extremes. The random tests fill
// the table to capacity, drain it, and then mix commands with random
// sender pauses. The last test sends commands back to back.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_DEPTH  = svl_pkg::DEPTH_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 150;

    // The block treats the spare command code as a no-op.
    localparam logic [svl_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam logic signed [svl_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [svl_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [svl_pkg::DATA_W-1:0] entry_value;
        logic [svl_pkg::STAT_W-1:0]        status;
        logic [svl_pkg::CNT_W-1:0]         entry_count;
        logic                              last;
    } result_beat_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [svl_pkg::CMD_W-1:0]         cmd = '0;
    logic signed [svl_pkg::DATA_W-1:0] value = '0;
    logic                              result_valid;
    logic signed [svl_pkg::DATA_W-1:0] entry_value;
    logic [svl_pkg::STAT_W-1:0]        status;
    logic [svl_pkg::CNT_W-1:0]         entry_count;
    logic                              last;

    // Local copy of the sorted table, kept in ascending order.
    logic signed [svl_pkg::DATA_W-1:0] sorted_vals[$];
    result_beat_t                      expected_beats[$];

    int  fail_count = 0;
    int  stall_cycles = 0;
    bit  pauses_on = 1'b1;

    sorted_value_list_top #(
        .DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .value       (value),
        .result_valid(result_valid),
        .entry_value (entry_value),
        .status      (status),
        .entry_count (entry_count),
        .last        (last)
    );

    always #6 clk = ~clk;

    function automatic void push_beat(logic signed [svl_pkg::DATA_W-1:0] ev,
                                      logic [svl_pkg::STAT_W-1:0] st, logic lst);
        result_beat_t b;
        b.entry_value = ev;
        b.status      = st;
        b.entry_count = svl_pkg::CNT_W'(sorted_vals.size());
        b.last        = lst;
        expected_beats.push_back(b);
    endfunction

    // Updates the table copy for one command and queues the beats it causes.
    function automatic void predict_table_op(logic [svl_pkg::CMD_W-1:0] c,
                                             logic signed [svl_pkg::DATA_W-1:0] v);
        int pos;
        pos = 0;
        case (c)
            svl_pkg::CMD_INSERT:
            begin
                if (sorted_vals.size() >= TABLE_DEPTH)
                begin
                    push_beat('0, svl_pkg::ST_FULL, 1'b1);
                end
                else
                begin
                    while (pos < sorted_vals.size() && sorted_vals[pos] < v)
                        pos++;
                    sorted_vals.insert(pos, v);
                    push_beat('0, svl_pkg::ST_OK, 1'b1);
                end
            end
            svl_pkg::CMD_REMOVE:
            begin
                while (pos < sorted_vals.size() && sorted_vals[pos] != v)
                    pos++;
                if (pos >= sorted_vals.size())
                begin
                    push_beat('0, svl_pkg::ST_NOTFOUND, 1'b1);
                end
                else
                begin
                    sorted_vals.delete(pos);
                    push_beat('0, svl_pkg::ST_OK, 1'b1);
                end
            end
            svl_pkg::CMD_LIST:
            begin
                if (sorted_vals.size() == 0)
                    push_beat('0, svl_pkg::ST_EMPTY, 1'b1);
                else
                    for (int i = 0; i < sorted_vals.size(); i++)
                        push_beat(sorted_vals[i], svl_pkg::ST_OK,
                                  i == sorted_vals.size() - 1);
            end
            default:
            begin
                push_beat('0, svl_pkg::ST_OK, 1'b1);
            end
        endcase
    endfunction

    // Start stays high after the beat is taken, so that a following command
    // can go out in the same cycle; pausing lowers it.
    task automatic send_command(logic [svl_pkg::CMD_W-1:0] c,
                                logic signed [svl_pkg::DATA_W-1:0] v);
        start <= 1'b1;
        cmd   <= c;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_table_op(c, v);
    endtask

    task automatic wait_results_drained();
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // Random sender gap; some gaps start only once the block has gone idle.
    task automatic sender_pause();
        if (pauses_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 2) == 0)
                wait_results_drained();
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    function automatic logic signed [svl_pkg::DATA_W-1:0] pick_value();
        logic signed [svl_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 20)) - 10;
            2: v = ($urandom_range(0, 1) == 0) ? VAL_MAX : VAL_MIN;
            3: v = $signed($urandom_range(0, 1000)) * 100 - 50000;
            default:
            begin
                if (sorted_vals.size() != 0)
                    v = sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
                else
                    v = $urandom;
            end
        endcase
        return v;
    endfunction

    // Removes mostly hit a stored value; the rest are likely misses.
    function automatic logic signed [svl_pkg::DATA_W-1:0] pick_remove_value();
        if (sorted_vals.size() != 0 && $urandom_range(0, 3) != 0)
            return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
        return pick_value();
    endfunction

    task automatic send_random_command(int insert_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            send_command(svl_pkg::CMD_INSERT, pick_value());
        else if (roll < 85)
            send_command(svl_pkg::CMD_REMOVE, pick_remove_value());
        else if (roll < 95)
            send_command(svl_pkg::CMD_LIST, $urandom);
        else
            send_command(CMD_SPARE, $urandom);
        sender_pause();
    endtask

    task automatic test_empty_table();
        send_command(svl_pkg::CMD_LIST, VAL_MAX);
        send_command(svl_pkg::CMD_REMOVE, '0);
        send_command(CMD_SPARE, VAL_MIN);
        sender_pause();
        send_command(svl_pkg::CMD_REMOVE, VAL_MIN);
    endtask

    task automatic test_extreme_values();
        send_command(svl_pkg::CMD_INSERT, VAL_MAX);
        send_command(svl_pkg::CMD_INSERT, VAL_MIN);
        sender_pause();
        send_command(svl_pkg::CMD_INSERT, '0);
        send_command(svl_pkg::CMD_INSERT, '0);
        send_command(svl_pkg::CMD_INSERT, -32'sd1);
        send_command(svl_pkg::CMD_INSERT, 32'sd1);
        send_command(svl_pkg::CMD_INSERT, VAL_MAX);
        send_command(svl_pkg::CMD_LIST, '0);
        sender_pause();
        send_command(svl_pkg::CMD_REMOVE, 32'sd12345);
        send_command(svl_pkg::CMD_REMOVE, '0);
        send_command(svl_pkg::CMD_REMOVE, VAL_MIN);
        send_command(svl_pkg::CMD_REMOVE, VAL_MAX);
        send_command(CMD_SPARE, '1);
        send_command(svl_pkg::CMD_LIST, '1);
        send_command(svl_pkg::CMD_REMOVE, VAL_MAX);
        send_command(svl_pkg::CMD_REMOVE, -32'sd1);
        send_command(svl_pkg::CMD_REMOVE, 32'sd1);
        send_command(svl_pkg::CMD_REMOVE, '0);
        send_command(svl_pkg::CMD_LIST, '0);
    endtask

    // Fill to capacity, poke the full table, then drain it again.
    task automatic test_fill_and_drain();
        while (sorted_vals.size() < TABLE_DEPTH)
            send_random_command(80);
        repeat (3)
        begin
            send_command(svl_pkg::CMD_INSERT, pick_value());
            sender_pause();
        end
        send_command(svl_pkg::CMD_LIST, '0);
        send_command(svl_pkg::CMD_REMOVE, pick_remove_value());
        send_command(svl_pkg::CMD_INSERT, VAL_MIN);
        send_command(svl_pkg::CMD_INSERT, VAL_MAX);
        send_command(svl_pkg::CMD_LIST, '0);
        while (sorted_vals.size() != 0)
        begin
            if ($urandom_range(0, 5) == 0)
                send_command(svl_pkg::CMD_LIST, $urandom);
            else
                send_command(svl_pkg::CMD_REMOVE, pick_remove_value());
            sender_pause();
        end
        send_command(svl_pkg::CMD_LIST, '0);
    endtask

    task automatic test_random_mix();
        repeat (100)
            send_random_command(sorted_vals.size() > 24 ? 30 : 55);
    endtask

    task automatic test_back_to_back();
        pauses_on = 1'b0;
        repeat (40)
            send_random_command(50);
    endtask

    always @(posedge clk)
    begin
        result_beat_t b;
        if (rst_n && result_valid)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: entry_value %0d status %0d", entry_value,
                       status);
                fail_count++;
            end
            else
            begin
                b = expected_beats.pop_front();
                if (entry_value !== b.entry_value)
                begin
                    $error("entry_value: expected %0d, got %0d", b.entry_value, entry_value);
                    fail_count++;
                end
                if (status !== b.status)
                begin
                    $error("status: expected %0d, got %0d", b.status, status);
                    fail_count++;
                end
                if (entry_count !== b.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", b.entry_count, entry_count);
                    fail_count++;
                end
                if (last !== b.last)
                begin
                    $error("last: expected %0d, got %0d", b.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if neither a command nor a result beat moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_extreme_values();
        test_fill_and_drain();
        test_random_mix();
        test_back_to_back();

        start <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/svl_pkg.sv
sv/svl_ram.sv
sv/svl_dp.sv
sv/svl_ctrl.sv
sv/sorted_value_list_top.sv
verif/testbench.sv
